// File: sv/grid_density_cluster_core_assert.svh
// ----------------------------------------------------------------------------
// Grid density clusterer assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_DENSITY_CLUSTER_CORE_ASSERT_SVH
`define GRID_DENSITY_CLUSTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GDC_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("grid density cluster check failed");
// next-cycle implication
`define GDC_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("grid density cluster check failed");
`else
`define GDC_ASSERT_IMP(lbl, clk, rst, a, b)
`define GDC_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

// File: sv/gdc_pkg.sv
// ----------------------------------------------------------------------------
// Grid density clusterer package
// Command codes, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
`default_nettype none
package gdc_pkg;

   localparam logic [2:0] K_CLEAR = 3'd0;
   localparam logic [2:0] K_ADD   = 3'd1;
   localparam logic [2:0] K_RUN   = 3'd2;
   localparam logic [2:0] K_RCELL = 3'd3;
   localparam logic [2:0] K_RCLU  = 3'd4;

   localparam logic [2:0] CSR_CLAT  = 3'd0;
   localparam logic [2:0] CSR_CFWD  = 3'd1;
   localparam logic [2:0] CSR_MWID  = 3'd2;
   localparam logic [2:0] CSR_MHGT  = 3'd3;
   localparam logic [2:0] CSR_SCALE = 3'd4;
   localparam logic [2:0] CSR_THR   = 3'd5;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam logic [29:0] SUM_MAX = 30'h3FFF_FFFF;

   typedef struct packed {
      logic [23:0] center_lateral;
      logic [23:0] center_forward;
      logic [22:0] map_width;
      logic [22:0] map_height;
      logic [15:0] cell_scale;
      logic [19:0] core_thresh;
   } gdc_cfg_type;

   localparam gdc_cfg_type CFG_RESET = '{
      center_lateral:    24'd0,
      center_forward:    24'd0,
      map_width:         23'd10240,
      map_height:        23'd10240,
      cell_scale:        16'd2560,
      core_thresh:       20'd100
   };

   // first member sits in the high bits
   typedef struct packed {
      logic [29:0] cluster_points;
      logic        cluster_overflow;
      logic [8:0]  cluster_total;
      logic [7:0]  cell_cluster;
      logic        cell_labeled;
      logic [15:0] cell_count;
      logic [6:0]  grid_row;
      logic [6:0]  grid_col;
      logic        point_accepted;
   } gdc_rsp_type;

endpackage
`default_nettype wire

// File: sv/gdc_point_map.sv
// ----------------------------------------------------------------------------
// Point to cell mapper
// Two-stage pipe: map offset and bounds, then scale to a cell and range check.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_point_map
   import gdc_pkg::*;
#(
   parameter int GRID_COLS = 128,
   parameter int GRID_ROWS = 128
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [23:0]                  lateral_pos,
   input  wire logic [23:0]                  forward_pos,
   input  wire gdc_cfg_type                  cfg,
   output logic                              map_ok,
   output logic [$clog2(GRID_COLS)-1:0]      map_col,
   output logic [$clog2(GRID_ROWS)-1:0]      map_row
);
   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);

   logic signed [25:0] px_s, py_s;
   logic               ok1_in;
   logic [22:0]        px_ff, py_ff;
   logic               ok1_ff;
   logic [38:0]        prod_c, prod_r;
   logic [20:0]        colw, roww;
   logic               ok_in, ok_ff;
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;

   assign px_s = $signed({4'b0, cfg.map_width[22:1]}) + 26'($signed(lateral_pos))
               - 26'($signed(cfg.center_lateral));
   assign py_s = $signed({4'b0, cfg.map_height[22:1]}) - 26'($signed(forward_pos))
               + 26'($signed(cfg.center_forward));
   assign ok1_in = !forward_pos[23] && !px_s[25] && !py_s[25]
                && (px_s < $signed({3'b0, cfg.map_width}))
                && (py_s < $signed({3'b0, cfg.map_height}));

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_s[22:0];
         py_ff  <= py_s[22:0];
         ok1_ff <= ok1_in;
      end
   end

   // Q10 metres times Q8 cells per metre gives Q18 cells
   assign prod_c = 39'(px_ff) * 39'(cfg.cell_scale);
   assign prod_r = 39'(py_ff) * 39'(cfg.cell_scale);
   assign colw   = prod_c[38:18];
   assign roww   = prod_r[38:18];
   assign ok_in  = ok1_ff && (32'(colw) < GRID_COLS) && (32'(roww) < GRID_ROWS);

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      col_ff <= CW'(colw);
      row_ff <= RW'(roww);
   end

   assign map_ok  = ok_ff;
   assign map_col = col_ff;
   assign map_row = row_ff;
endmodule
`default_nettype wire

// File: sv/gdc_engine.sv
// ----------------------------------------------------------------------------
// Grid density cluster engine
// Sequencer over the count, label, queue and sum memories: binning, reads,
// clearing sweeps and the flood-fill clustering walk.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_engine
   import gdc_pkg::*;
#(
   parameter int GRID_COLS    = 128,
   parameter int GRID_ROWS    = 128,
   parameter int WINDOW       = 3,
   parameter int MAX_CLUSTERS = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [2:0]                   kind,
   input  wire logic [6:0]                   cell_col,
   input  wire logic [6:0]                   cell_row,
   input  wire logic [7:0]                   cluster_index,
   input  wire gdc_cfg_type                  cfg,
   input  wire logic                         map_ok,
   input  wire logic [$clog2(GRID_COLS)-1:0] map_col,
   input  wire logic [$clog2(GRID_ROWS)-1:0] map_row,
   input  wire logic                         out_free,
   output logic                              ready,
   output logic                              done,
   output gdc_rsp_type                       res
);
   localparam int NCELLS = GRID_COLS * GRID_ROWS;
   localparam int AW     = $clog2(NCELLS);
   localparam int CW     = $clog2(GRID_COLS);
   localparam int RW     = $clog2(GRID_ROWS);
   localparam int QW     = RW + CW;
   localparam int IW     = $clog2(MAX_CLUSTERS);
   localparam int TW     = $clog2(MAX_CLUSTERS + 1);
   localparam int HALF   = WINDOW / 2;
   localparam int NB     = WINDOW * WINDOW;
   localparam int NCW    = $clog2(NB);
   localparam int CIW    = $clog2(NB - 1);
   localparam int DW     = 16 + $clog2(NB);
   localparam int SWN    = (NCELLS > MAX_CLUSTERS) ? NCELLS : MAX_CLUSTERS;
   localparam int SWW    = $clog2(SWN);
   localparam int LWW    = IW + QW + 2;  // {unlabeled, id, mark valid, mark seed}

   localparam logic [4:0] ST_INIT  = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_CLR   = 5'd2;
   localparam logic [4:0] ST_ADD0  = 5'd3;
   localparam logic [4:0] ST_ADD1  = 5'd4;
   localparam logic [4:0] ST_ADD2  = 5'd5;
   localparam logic [4:0] ST_RC0   = 5'd6;
   localparam logic [4:0] ST_RC1   = 5'd7;
   localparam logic [4:0] ST_RS0   = 5'd8;
   localparam logic [4:0] ST_RS1   = 5'd9;
   localparam logic [4:0] ST_RCLR  = 5'd10;
   localparam logic [4:0] ST_SISS  = 5'd11;
   localparam logic [4:0] ST_SCHK  = 5'd12;
   localparam logic [4:0] ST_WSEED = 5'd13;
   localparam logic [4:0] ST_QRD   = 5'd14;
   localparam logic [4:0] ST_QDAT  = 5'd15;
   localparam logic [4:0] ST_PDAT  = 5'd16;
   localparam logic [4:0] ST_NISS  = 5'd17;
   localparam logic [4:0] ST_NCHK  = 5'd18;
   localparam logic [4:0] ST_DEC   = 5'd19;
   localparam logic [4:0] ST_PUSH  = 5'd20;
   localparam logic [4:0] ST_WEND  = 5'd21;
   localparam logic [4:0] ST_RFIN  = 5'd22;
   localparam logic [4:0] ST_RESP  = 5'd23;

   localparam logic [LWW-1:0] LAB_CLEAR = {1'b1, (LWW-1)'(0)};

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
      cell_addr = AW'(32'(r) * GRID_COLS + 32'(c));
   endfunction

   // memories
   logic [15:0]     cnt_mem [NCELLS];
   logic [LWW-1:0]  lab_mem [NCELLS];
   logic [QW-1:0]   q_mem   [NCELLS];
   logic [29:0]     sum_mem [MAX_CLUSTERS];

   logic [15:0]     cnt_q;
   logic [LWW-1:0]  lab_q;
   logic [QW-1:0]   q_q;
   logic [29:0]     sum_q;

   logic [AW-1:0]   rd_addr, q_ra, cnt_wa, lab_wa, q_wa;
   logic [IW-1:0]   s_ra, s_wa;
   logic            cnt_we, lab_we, q_we, s_we;
   logic [15:0]     cnt_wd;
   logic [LWW-1:0]  lab_wd;
   logic [QW-1:0]   q_wd;
   logic [29:0]     s_wd;

   always_ff @(posedge clock) begin
      cnt_q <= cnt_mem[rd_addr];
      lab_q <= lab_mem[rd_addr];
      q_q   <= q_mem[q_ra];
      sum_q <= sum_mem[s_ra];
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (lab_we) lab_mem[lab_wa] <= lab_wd;
      if (q_we)   q_mem[q_wa]     <= q_wd;
      if (s_we)   sum_mem[s_wa]   <= s_wd;
   end

   // registers
   logic [4:0]        state_ff, state_in;
   logic [6:0]        rcc_ff, rcc_in, rcr_ff, rcr_in;
   logic [7:0]        idx_ff, idx_in;
   logic [SWW-1:0]    sw_ff, sw_in;
   logic [RW-1:0]     sr_ff, sr_in, pr_ff, pr_in;
   logic [CW-1:0]     sc_ff, sc_in, pc_ff, pc_in;
   logic [QW-1:0]     seed_ff, seed_in, qn_ff, qn_in;
   logic [AW:0]       k_ff, k_in, qlen_ff, qlen_in;
   logic [15:0]       pcnt_ff, pcnt_in;
   logic [QW:0]       pmark_ff, pmark_in;
   logic signed [3:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [DW-1:0]     dens_ff, dens_in;
   logic [QW-1:0]     cand_ff [NB-1];
   logic              cand_we;
   logic [NCW-1:0]    nc_ff, nc_in, pi_ff, pi_in;
   logic [29:0]       acc_ff, acc_in;
   logic              seedlab_ff, seedlab_in;
   logic [TW-1:0]     total_ff, total_in;
   logic              ovf_ff, ovf_in;
   gdc_rsp_type       res_ff, res_in;

   // helpers
   logic signed [RW+1:0] nr_s;
   logic signed [CW+1:0] ncol_s;
   logic                 nb_ok, nb_last, last_cell, live, marked, unl_q, rc_ok, rs_ok;
   logic [QW-1:0]        nb_q;
   logic [IW-1:0]        cur_id;
   logic [30:0]          sum_w;
   logic [29:0]          sum_sat;
   logic signed [3:0]    dr_nx, dc_nx;

   assign nr_s   = $signed({2'b00, pr_ff}) + (RW+2)'(dr_ff);
   assign ncol_s = $signed({2'b00, pc_ff}) + (CW+2)'(dc_ff);
   assign nb_ok  = !(dr_ff == 4'sd0 && dc_ff == 4'sd0)
                && !nr_s[RW+1] && (nr_s < $signed((RW+2)'(GRID_ROWS)))
                && !ncol_s[CW+1] && (ncol_s < $signed((CW+2)'(GRID_COLS)));
   assign nb_q   = {nr_s[RW-1:0], ncol_s[CW-1:0]};
   assign nb_last = (dr_ff > $signed(4'(HALF)));
   assign dc_nx  = (dc_ff == 4'(HALF)) ? -4'sd1 * 4'(HALF) : dc_ff + 4'sd1;
   assign dr_nx  = (dc_ff == 4'(HALF)) ? dr_ff + 4'sd1 : dr_ff;

   assign last_cell = (32'(sr_ff) == GRID_ROWS - 1) && (32'(sc_ff) == GRID_COLS - 1);
   assign live      = (32'(total_ff) < MAX_CLUSTERS);
   assign cur_id    = live ? IW'(total_ff) : '0;
   assign unl_q     = lab_q[LWW-1];
   assign marked    = lab_q[QW] && (lab_q[QW-1:0] == seed_ff);
   assign sum_w     = {1'b0, acc_ff} + 31'(pcnt_ff);
   assign sum_sat   = sum_w[30] ? SUM_MAX : sum_w[29:0];
   assign rc_ok     = (32'(rcc_ff) < GRID_COLS) && (32'(rcr_ff) < GRID_ROWS);
   assign rs_ok     = (32'(idx_ff) < 32'(total_ff)) && (32'(idx_ff) < MAX_CLUSTERS);

   always_comb begin
      state_in   = state_ff;
      rcc_in     = rcc_ff;
      rcr_in     = rcr_ff;
      idx_in     = idx_ff;
      sw_in      = sw_ff;
      sr_in      = sr_ff;
      sc_in      = sc_ff;
      pr_in      = pr_ff;
      pc_in      = pc_ff;
      seed_in    = seed_ff;
      qn_in      = qn_ff;
      k_in       = k_ff;
      qlen_in    = qlen_ff;
      pcnt_in    = pcnt_ff;
      pmark_in   = pmark_ff;
      dr_in      = dr_ff;
      dc_in      = dc_ff;
      dens_in    = dens_ff;
      nc_in      = nc_ff;
      pi_in      = pi_ff;
      acc_in     = acc_ff;
      seedlab_in = seedlab_ff;
      total_in   = total_ff;
      ovf_in     = ovf_ff;
      res_in     = res_ff;
      cand_we    = 1'b0;
      rd_addr    = '0;
      q_ra       = '0;
      s_ra       = '0;
      cnt_we     = 1'b0;
      cnt_wa     = '0;
      cnt_wd     = '0;
      lab_we     = 1'b0;
      lab_wa     = '0;
      lab_wd     = LAB_CLEAR;
      q_we       = 1'b0;
      q_wa       = '0;
      q_wd       = '0;
      s_we       = 1'b0;
      s_wa       = '0;
      s_wd       = '0;
      done       = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            cnt_we = (32'(sw_ff) < NCELLS);
            cnt_wa = sw_ff[AW-1:0];
            lab_we = (32'(sw_ff) < NCELLS);
            lab_wa = sw_ff[AW-1:0];
            s_we   = (32'(sw_ff) < MAX_CLUSTERS);
            s_wa   = sw_ff[IW-1:0];
            sw_in  = sw_ff + 1'b1;
            if (32'(sw_ff) == SWN - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               rcc_in  = cell_col;
               rcr_in  = cell_row;
               idx_in  = cluster_index;
               res_in  = '0;
               sw_in   = '0;
               unique case (kind)
                  K_CLEAR: state_in = ST_CLR;
                  K_ADD:   state_in = ST_ADD0;
                  K_RUN: begin
                     total_in = '0;
                     ovf_in   = 1'b0;
                     state_in = ST_RCLR;
                  end
                  K_RCELL: state_in = ST_RC0;
                  K_RCLU:  state_in = ST_RS0;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_CLR: begin
            cnt_we = 1'b1;
            cnt_wa = sw_ff[AW-1:0];
            sw_in  = sw_ff + 1'b1;
            if (32'(sw_ff) == NCELLS - 1) state_in = ST_RESP;
         end
         ST_ADD0: state_in = ST_ADD1;
         ST_ADD1: begin
            rd_addr  = cell_addr(map_row, map_col);
            state_in = map_ok ? ST_ADD2 : ST_RESP;
         end
         ST_ADD2: begin
            cnt_we = 1'b1;
            cnt_wa = cell_addr(map_row, map_col);
            cnt_wd = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 16'd1;
            res_in.point_accepted = 1'b1;
            res_in.grid_col = 7'(map_col);
            res_in.grid_row = 7'(map_row);
            state_in = ST_RESP;
         end
         ST_RC0: begin
            rd_addr  = cell_addr(RW'(rcr_ff), CW'(rcc_ff));
            state_in = ST_RC1;
         end
         ST_RC1: begin
            if (rc_ok) begin
               res_in.cell_count   = cnt_q;
               res_in.cell_labeled = !unl_q;
               res_in.cell_cluster = unl_q ? 8'd0 : 8'(lab_q[LWW-2 -: IW]);
            end
            state_in = ST_RESP;
         end
         ST_RS0: begin
            s_ra     = IW'(idx_ff);
            state_in = ST_RS1;
         end
         ST_RS1: begin
            res_in.cluster_total    = 9'(total_ff);
            res_in.cluster_overflow = ovf_ff;
            res_in.cluster_points   = rs_ok ? sum_q : 30'd0;
            state_in = ST_RESP;
         end
         ST_RCLR: begin
            lab_we = (32'(sw_ff) < NCELLS);
            lab_wa = sw_ff[AW-1:0];
            s_we   = (32'(sw_ff) < MAX_CLUSTERS);
            s_wa   = sw_ff[IW-1:0];
            sw_in  = sw_ff + 1'b1;
            if (32'(sw_ff) == SWN - 1) begin
               sr_in    = '0;
               sc_in    = '0;
               state_in = ST_SISS;
            end
         end
         ST_SISS: begin
            rd_addr  = cell_addr(sr_ff, sc_ff);
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (unl_q && cnt_q != 16'd0) begin
               seed_in  = {sr_ff, sc_ff};
               state_in = ST_WSEED;
            end else if (last_cell) begin
               state_in = ST_RFIN;
            end else begin
               state_in = ST_SISS;
               if (32'(sc_ff) == GRID_COLS - 1) begin
                  sc_in = '0;
                  sr_in = sr_ff + 1'b1;
               end else begin
                  sc_in = sc_ff + 1'b1;
               end
            end
         end
         ST_WSEED: begin
            // mark the seed as queued for this walk
            lab_we     = 1'b1;
            lab_wa     = cell_addr(sr_ff, sc_ff);
            lab_wd     = {1'b1, IW'(0), 1'b1, seed_ff};
            q_we       = 1'b1;
            q_wa       = '0;
            q_wd       = seed_ff;
            k_in       = '0;
            qlen_in    = (AW+1)'(1);
            acc_in     = '0;
            seedlab_in = 1'b0;
            state_in   = ST_QRD;
         end
         ST_QRD: begin
            q_ra     = k_ff[AW-1:0];
            state_in = (k_ff < qlen_ff) ? ST_QDAT : ST_WEND;
         end
         ST_QDAT: begin
            pr_in    = q_q[QW-1:CW];
            pc_in    = q_q[CW-1:0];
            rd_addr  = cell_addr(q_q[QW-1:CW], q_q[CW-1:0]);
            state_in = ST_PDAT;
         end
         ST_PDAT: begin
            pcnt_in  = cnt_q;
            pmark_in = lab_q[QW:0];
            dr_in    = -4'sd1 * 4'(HALF);
            dc_in    = -4'sd1 * 4'(HALF);
            dens_in  = '0;
            nc_in    = '0;
            state_in = ST_NISS;
         end
         ST_NISS: begin
            if (nb_last) begin
               state_in = ST_DEC;
            end else begin
               dr_in = dr_nx;
               dc_in = dc_nx;
               if (nb_ok) begin
                  rd_addr  = cell_addr(nb_q[QW-1:CW], nb_q[CW-1:0]);
                  qn_in    = nb_q;
                  state_in = ST_NCHK;
               end
            end
         end
         ST_NCHK: begin
            if (cnt_q != 16'd0) begin
               dens_in = dens_ff + DW'(cnt_q);
               if (unl_q && !marked) begin
                  cand_we = 1'b1;
                  nc_in   = nc_ff + 1'b1;
                  lab_we  = 1'b1;
                  lab_wa  = cell_addr(qn_ff[QW-1:CW], qn_ff[CW-1:0]);
                  lab_wd  = {lab_q[LWW-1:QW+1], 1'b1, seed_ff};
               end
            end
            state_in = ST_NISS;
         end
         ST_DEC: begin
            k_in  = k_ff + 1'b1;
            pi_in = '0;
            if (32'(dens_ff) > 32'(cfg.core_thresh)) begin
               if (live) begin
                  lab_we = 1'b1;
                  lab_wa = cell_addr(pr_ff, pc_ff);
                  lab_wd = {1'b0, cur_id, pmark_ff};
                  acc_in = sum_sat;
                  if (k_ff == '0) seedlab_in = 1'b1;
               end
               state_in = ST_PUSH;
            end else begin
               state_in = ST_QRD;
            end
         end
         ST_PUSH: begin
            if (pi_ff < nc_ff && 32'(qlen_ff) < NCELLS) begin
               q_we    = 1'b1;
               q_wa    = qlen_ff[AW-1:0];
               q_wd    = cand_ff[pi_ff[CIW-1:0]];
               qlen_in = qlen_ff + 1'b1;
               pi_in   = pi_ff + 1'b1;
            end else begin
               state_in = ST_QRD;
            end
         end
         ST_WEND: begin
            s_we = live;
            s_wa = cur_id;
            if (qlen_ff > (AW+1)'(1)) begin
               s_wd = acc_ff;
               if (live) total_in = total_ff + 1'b1;
               else      ovf_in   = 1'b1;
            end else if (live && seedlab_ff) begin
               // drop the lone seed's label
               lab_we = 1'b1;
               lab_wa = cell_addr(sr_ff, sc_ff);
               lab_wd = {1'b1, IW'(0), 1'b1, seed_ff};
            end
            if (last_cell) begin
               state_in = ST_RFIN;
            end else begin
               state_in = ST_SISS;
               if (32'(sc_ff) == GRID_COLS - 1) begin
                  sc_in = '0;
                  sr_in = sr_ff + 1'b1;
               end else begin
                  sc_in = sc_ff + 1'b1;
               end
            end
         end
         ST_RFIN: begin
            res_in.cluster_total    = 9'(total_ff);
            res_in.cluster_overflow = ovf_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sw_ff    <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sw_ff    <= sw_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      rcc_ff     <= rcc_in;
      rcr_ff     <= rcr_in;
      idx_ff     <= idx_in;
      sr_ff      <= sr_in;
      sc_ff      <= sc_in;
      pr_ff      <= pr_in;
      pc_ff      <= pc_in;
      seed_ff    <= seed_in;
      qn_ff      <= qn_in;
      k_ff       <= k_in;
      qlen_ff    <= qlen_in;
      pcnt_ff    <= pcnt_in;
      pmark_ff   <= pmark_in;
      dr_ff      <= dr_in;
      dc_ff      <= dc_in;
      dens_ff    <= dens_in;
      nc_ff      <= nc_in;
      pi_ff      <= pi_in;
      acc_ff     <= acc_in;
      seedlab_ff <= seedlab_in;
      res_ff     <= res_in;
      if (cand_we) cand_ff[nc_ff[CIW-1:0]] <= qn_ff;
   end

   assign ready = (state_ff == ST_IDLE);
   assign res   = res_ff;
endmodule
`default_nettype wire

// File: sv/grid_density_cluster_core.sv
// ----------------------------------------------------------------------------
// Grid density clusterer top level
// Usage: req_ beats carry one command each (tuser = kind): clear grid, add
// point, run clustering, read cell, read cluster. Every command returns
// exactly one rsp_ beat. Registers must be written on csr_ only while the
// block is idle; the block itself does not enforce this. One command is in
// flight at a time; req_tready is high only while the sequencer waits for a
// command. Add point: the result follows the mapper pipe and a count
// read-modify-write. Read cell / read cluster: the result follows one read.
// Clear grid: a sweep zeroes every cell count before the result.
// Run: a sweep clears labels and sums over max(GRID_COLS*GRID_ROWS,
// MAX_CLUSTERS) entries, then a scan visits each cell; each walk reads every
// queued cell, steps through each window position with a read per in-grid
// neighbour, and after a core cell pushes each candidate onto the queue.
// Reset starts a clearing pass of max(GRID_COLS*GRID_ROWS, MAX_CLUSTERS)
// entries over the memories; no command is taken until it ends.
// A finished result waits in the output register while rsp_tready is low;
// the sequencer holds in its result state until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_density_cluster_core_assert.svh"
module grid_density_cluster_core
   import gdc_pkg::*;
#(
   parameter int GRID_COLS    = 128,
   parameter int GRID_ROWS    = 128,
   parameter int WINDOW       = 3,
   parameter int MAX_CLUSTERS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // lateral_pos, forward_pos, cell_col, cell_row, cluster_index, zero pad
   input  wire logic [71:0] req_tdata,
   // kind
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // point_accepted, grid_col, grid_row, cell_count, cell_labeled,
   // cell_cluster, cluster_total, cluster_overflow, cluster_points
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   gdc_cfg_type cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gdc_rsp_type rsp_data_ff, rsp_data_in;
   logic        accept, eng_ready, eng_done, out_free, map_ok;
   gdc_rsp_type eng_res;
   logic [$clog2(GRID_COLS)-1:0] map_col;
   logic [$clog2(GRID_ROWS)-1:0] map_row;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CLAT:  cfg_in.center_lateral    = csr_wdata;
            CSR_CFWD:  cfg_in.center_forward    = csr_wdata;
            CSR_MWID:  cfg_in.map_width         = csr_wdata[22:0];
            CSR_MHGT:  cfg_in.map_height        = csr_wdata[22:0];
            CSR_SCALE: cfg_in.cell_scale        = csr_wdata[15:0];
            CSR_THR:   cfg_in.core_thresh       = csr_wdata[19:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = eng_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   gdc_point_map #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_map (
      .clock       (clock),
      .en          (accept),
      .lateral_pos (req_tdata[23:0]),
      .forward_pos (req_tdata[47:24]),
      .cfg         (cfg_ff),
      .map_ok      (map_ok),
      .map_col     (map_col),
      .map_row     (map_row)
   );

   gdc_engine #(
      .GRID_COLS    (GRID_COLS),
      .GRID_ROWS    (GRID_ROWS),
      .WINDOW       (WINDOW),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .kind          (req_tuser),
      .cell_col      (req_tdata[54:48]),
      .cell_row      (req_tdata[61:55]),
      .cluster_index (req_tdata[69:62]),
      .cfg           (cfg_ff),
      .map_ok        (map_ok),
      .map_col       (map_col),
      .map_row       (map_row),
      .out_free      (out_free),
      .ready         (eng_ready),
      .done          (eng_done),
      .res           (eng_res)
   );

   // load on done, drop once the beat is taken
   assign rsp_valid_in = eng_done ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = eng_done ? eng_res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `GDC_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `GDC_ASSERT_IMP(a_done_needs_room, clock, reset, eng_done, out_free)
   `GDC_ASSERT_IMP(a_add_result_clean, clock, reset,
      rsp_valid_ff && rsp_data_ff.point_accepted,
      rsp_data_ff.cell_count == 16'd0 && rsp_data_ff.cluster_total == 9'd0)
endmodule
`default_nettype wire
